@@ rtl/core/slet_pkg.sv @@
// ---------------------------------------------------------------------------
// slet_pkg: shared types and constants of the sorted leaf entry table
// Entry layout, command, status and sequencer codes, and chain dimensions.
// ---------------------------------------------------------------------------
`default_nettype none

package slet_pkg;

  // Table dimensions; one spare cell holds the extra entry during a split
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned NCELL    = CAPACITY + 1;

  // Field widths
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned PAGE_W = 31;
  localparam int unsigned SLOT_W = 16;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned STS_W  = 3;
  localparam int unsigned CMD_W  = 2;

  // Read-select tree: cells per first-level group
  localparam int unsigned GRP  = 8;
  localparam int unsigned NGRP = (NCELL + GRP - 1) / GRP;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAGE_W-1:0]       page;
    logic [SLOT_W-1:0]       slot;
  } entry_t;

  // Broadcast control into one cell
  typedef struct packed {
    logic ins_en;  // insert step: shift up or take the new entry
    logic occ;     // cell lies below the held count
  } cell_ctrl_t;

  // Registered compare result of one cell
  typedef struct packed {
    logic lt;      // occupied and stored key below search key
    logic eq;      // occupied and stored key equals search key
  } cell_flags_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOCATE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SPLIT  = 2'd3
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_FULL      = 3'd2,
    STS_DUP       = 3'd3,
    STS_BAD_INDEX = 3'd4,
    STS_ZERO_KEY  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_CMP  = 3'd1,
    S_EXEC = 3'd2,
    S_ESEL = 3'd3,
    S_EOUT = 3'd4
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/slet_if.sv @@
// ---------------------------------------------------------------------------
// slet_if: request and response channels of the sorted leaf entry table
// Valid/ready channels; a transaction moves when valid and ready are high.
// ---------------------------------------------------------------------------
`default_nettype none

interface slet_in_if import slet_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [KEY_W-1:0] key;
  logic [PAGE_W-1:0]       rid_page;
  logic [SLOT_W-1:0]       rid_slot;
  logic [IDX_W-1:0]        entry_index;

  modport source (output valid, cmd, key, rid_page, rid_slot, entry_index, input ready);
  modport sink   (input valid, cmd, key, rid_page, rid_slot, entry_index, output ready);
endinterface

interface slet_out_if import slet_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STS_W-1:0]        status;
  logic [IDX_W-1:0]        position;
  logic signed [KEY_W-1:0] out_key;
  logic [PAGE_W-1:0]       out_page;
  logic [SLOT_W-1:0]       out_slot;
  logic [CNT_W-1:0]        entry_count;
  logic                    last;

  modport source (output valid, status, position, out_key, out_page, out_slot,
                  entry_count, last, input ready);
  modport sink   (input valid, status, position, out_key, out_page, out_slot,
                  entry_count, last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/slet_cell.sv @@
// ---------------------------------------------------------------------------
// slet_cell: one entry slot of the sorted chain
// Holds an entry, compares it with the search key and, on an insert step,
// takes its lower neighbor's entry or the new entry.
// ---------------------------------------------------------------------------
`default_nettype none

module slet_cell import slet_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cell_ctrl_t              ctrl_i,
  input  wire logic                    prev_lt_i,
  input  wire logic signed [KEY_W-1:0] srch_key_i,
  input  wire entry_t                  new_i,
  input  wire entry_t                  prev_i,
  output      entry_t                  entry_o,
  output      cell_flags_t             flags_o
);

  entry_t      entry_q;
  cell_flags_t flags_q;

  // Compare against the search key every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q.lt <= ctrl_i.occ && ($signed(entry_q.key) < $signed(srch_key_i));
      flags_q.eq <= ctrl_i.occ && (entry_q.key == srch_key_i);
    end
  end

  // Insert step: cells above the insert point shift up, the cell at it loads
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_en) begin
      if (!prev_lt_i) begin
        entry_q <= prev_i;
      end else if (!flags_q.lt) begin
        entry_q <= new_i;
      end
    end
  end

  assign entry_o = entry_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

@@ rtl/core/slet_sel.sv @@
// ---------------------------------------------------------------------------
// slet_sel: registered read-select tree over the cell chain
// First level ORs the addressed cell out of each group into a register;
// second level ORs the group registers.
// ---------------------------------------------------------------------------
`default_nettype none

module slet_sel import slet_pkg::*; (
  input  wire logic             clk_i,
  input  wire entry_t           cells_i [NCELL],
  input  wire logic [IDX_W-1:0] idx_i,
  output      entry_t           entry_o
);

  entry_t grp_d [NGRP];
  entry_t grp_q [NGRP];

  // Group-level one-hot select
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if ((g * GRP + j) < NCELL) begin
          if (idx_i == IDX_W'(g * GRP + j)) begin
            grp_d[g] = grp_d[g] | cells_i[g * GRP + j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  // Merge groups
  always_comb begin
    entry_o = '0;
    for (int g = 0; g < NGRP; g++) begin
      entry_o = entry_o | grp_q[g];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sorted_leaf_entry_table.sv @@
// ---------------------------------------------------------------------------
// sorted_leaf_entry_table: ascending key table of a B+ tree leaf
// Chain of entry cells with a sequencer for insert, locate, read and split.
// ---------------------------------------------------------------------------
// Usage:
//   in_i  : one request transaction (cmd, key, rid_page, rid_slot,
//           entry_index). Taken only while the block is idle.
//   out_o : response transactions. Insert, locate and read give one, with
//           last set. A successful split gives one per entry moved to the
//           sibling, in ascending key order, last set on the final one;
//           the first carries the sibling key.
//   Timing: a request is registered on acceptance, compared in the cycle
//   after, and answered in the next unless the output register is still
//   held. The next request is taken only once the sequencer is back in
//   idle, so a request is not accepted before the last one is answered.
//   The chain compare and the two-level read-select tree are registered.
//   Each split response passes through the select-tree register, then the
//   output register.
//   Reset: the held count goes to zero, the table is empty, no response
//   is pending.
//   Stall: a response held in the output register waits for out_o.ready;
//   a sequencer with a further response waits; while idle it takes requests.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_leaf_entry_table import slet_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  slet_in_if.sink     in_i,
  slet_out_if.source  out_o
);

  // Sequencer and request registers
  state_e                  state_q, state_d;
  cmd_e                    cmd_q;
  logic signed [KEY_W-1:0] key_q;
  entry_t                  new_q;
  logic [IDX_W-1:0]        idx_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [IDX_W-1:0]        emit_q, emit_d;
  logic [CNT_W-1:0]        hi_q, hi_d;

  // Output register
  logic                    out_valid_q;
  status_e                 out_status_q;
  logic [IDX_W-1:0]        out_pos_q;
  entry_t                  out_entry_q;
  logic [CNT_W-1:0]        out_cnt_q;
  logic                    out_last_q;

  // Response being formed
  logic                    res_load;
  status_e                 res_status;
  logic [IDX_W-1:0]        res_pos;
  entry_t                  res_entry;
  logic [CNT_W-1:0]        res_cnt;
  logic                    res_last;
  logic                    ins_en;

  // Chain signals
  entry_t                  cell_ent [NCELL];
  cell_flags_t             cell_flg [NCELL];
  cell_ctrl_t              cell_ctl [NCELL];
  logic [NCELL-1:0]        lt_vec;
  logic [NCELL-1:0]        eq_vec;
  logic [NCELL-1:0]        prev_lt;
  logic [IDX_W-1:0]        ins_pos;
  logic                    hit;
  entry_t                  sel_entry;
  logic [IDX_W-1:0]        sel_idx;

  logic                    in_fire;
  logic                    out_free;
  logic                    key_zero;
  logic                    full;
  logic [CNT_W-1:0]        cnt_inc;
  logic [CNT_W-1:0]        keep;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign key_zero = (key_q == '0);
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign cnt_inc  = count_q + CNT_W'(1);
  assign keep     = cnt_inc >> 1;

  assign in_i.ready = (state_q == S_IDLE);

  // Cell chain
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    assign cell_ctl[i].ins_en = ins_en;
    assign cell_ctl[i].occ    = (CNT_W'(i) < count_q);
    assign lt_vec[i]          = cell_flg[i].lt;
    assign eq_vec[i]          = cell_flg[i].eq;

    if (i == 0) begin : g_head
      assign prev_lt[i] = 1'b1;
      slet_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (cell_ctl[i]),
        .prev_lt_i  (prev_lt[i]),
        .srch_key_i (key_q),
        .new_i      (new_q),
        .prev_i     (new_q),
        .entry_o    (cell_ent[i]),
        .flags_o    (cell_flg[i])
      );
    end else begin : g_body
      assign prev_lt[i] = lt_vec[i-1];
      slet_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (cell_ctl[i]),
        .prev_lt_i  (prev_lt[i]),
        .srch_key_i (key_q),
        .new_i      (new_q),
        .prev_i     (cell_ent[i-1]),
        .entry_o    (cell_ent[i]),
        .flags_o    (cell_flg[i])
      );
    end
  end

  // Insert point: the lt bits form a run of ones from cell 0; find its end
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < NCELL; i++) begin
      if (lt_vec[i] && ((i == NCELL - 1) || !lt_vec[(i + 1) % NCELL])) begin
        ins_pos = ins_pos | IDX_W'(i + 1);
      end
    end
  end

  assign hit = |eq_vec;

  // Read path
  assign sel_idx = ((state_q == S_ESEL) || (state_q == S_EOUT)) ? emit_q : idx_q;

  slet_sel u_sel (
    .clk_i   (clk_i),
    .cells_i (cell_ent),
    .idx_i   (sel_idx),
    .entry_o (sel_entry)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_q == CMD_SPLIT && !key_zero && !hit) begin
          state_d = S_ESEL;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_ESEL: begin
        state_d = S_EOUT;
      end
      S_EOUT: begin
        if (out_free) begin
          state_d = (emit_q == hi_q) ? S_IDLE : S_ESEL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Command decode, table update and response
  always_comb begin
    res_load   = 1'b0;
    res_status = STS_OK;
    res_pos    = '0;
    res_entry  = '0;
    res_cnt    = count_q;
    res_last   = 1'b1;
    ins_en     = 1'b0;
    count_d    = count_q;
    emit_d     = emit_q;
    hi_d       = hi_q;
    unique case (state_q)
      S_EXEC: begin
        priority if (cmd_q == CMD_READ) begin
          res_load = out_free;
          res_pos  = idx_q;
          if (idx_q >= count_q) begin
            res_status = STS_BAD_INDEX;
          end else begin
            res_entry = sel_entry;
          end
        end else if (key_zero) begin
          res_load   = out_free;
          res_status = STS_ZERO_KEY;
        end else if (cmd_q == CMD_LOCATE) begin
          res_load   = out_free;
          res_status = hit ? STS_OK : STS_NOT_FOUND;
          res_pos    = ins_pos;
        end else if (hit) begin
          res_load   = out_free;
          res_status = STS_DUP;
          res_pos    = ins_pos;
        end else if (cmd_q == CMD_INSERT) begin
          res_load = out_free;
          if (full) begin
            res_status = STS_FULL;
          end else begin
            res_pos = ins_pos;
            res_cnt = cnt_inc;
            ins_en  = out_free;
            if (out_free) count_d = cnt_inc;
          end
        end else begin
          // split: merge the new entry, keep the lower half
          ins_en  = 1'b1;
          count_d = keep;
          emit_d  = keep;
          hi_d    = count_q;
        end
      end
      S_EOUT: begin
        res_load  = out_free;
        res_pos   = emit_q - count_q;
        res_entry = sel_entry;
        res_last  = (emit_q == hi_q);
        if (out_free && (emit_q != hi_q)) emit_d = emit_q + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      emit_q      <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      emit_q  <= emit_d;
      hi_q    <= hi_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q      <= cmd_e'(in_i.cmd);
      key_q      <= in_i.key;
      new_q.key  <= in_i.key;
      new_q.page <= in_i.rid_page;
      new_q.slot <= in_i.rid_slot;
      idx_q      <= in_i.entry_index;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_status_q <= res_status;
      out_pos_q    <= res_pos;
      out_entry_q  <= res_entry;
      out_cnt_q    <= res_cnt;
      out_last_q   <= res_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.position    = out_pos_q;
  assign out_o.out_key     = out_entry_q.key;
  assign out_o.out_page    = out_entry_q.page;
  assign out_o.out_slot    = out_entry_q.slot;
  assign out_o.entry_count = out_cnt_q;
  assign out_o.last        = out_last_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_sorted_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> (((lt_vec >> 1) & ~lt_vec) == '0))
    else $error("compare bits not a prefix run: table out of order");

  a_unique_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> $onehot0(eq_vec))
    else $error("key held in more than one cell");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EOUT) |-> (emit_q >= count_q && emit_q <= hi_q))
    else $error("split emit index outside sibling range");

endmodule

`default_nettype wire

@@ sim/sorted_leaf_entry_table_tb.sv @@
// ---------------------------------------------------------------------------
// sorted_leaf_entry_table_tb: self-checking bench for the sorted leaf table
// Drives insert, locate, read and split requests through the valid/ready
// request channel and checks every response against a behavioral table
// model. A short directed prologue is followed by phases that fill the
// table to capacity, split it, and mix random commands under shifting idle
// patterns and one long response back-pressure stretch.
// ---------------------------------------------------------------------------
module sorted_leaf_entry_table_tb import slet_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    cmd_e                    cmd;
    logic signed [KEY_W-1:0] key;
    logic [PAGE_W-1:0]       page;
    logic [SLOT_W-1:0]       slot;
    logic [IDX_W-1:0]        idx;
  } leaf_req_t;

  typedef struct {
    status_e                 status;
    logic [IDX_W-1:0]        position;
    logic signed [KEY_W-1:0] key;
    logic [PAGE_W-1:0]       page;
    logic [SLOT_W-1:0]       slot;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } leaf_resp_t;

  logic clk_i;
  logic rst_ni;

  slet_in_if  in_if ();
  slet_out_if out_if ();

  sorted_leaf_entry_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Pending requests, expected responses, request on the bus
  leaf_req_t               req_q[$];
  leaf_resp_t              resp_q[$];
  leaf_req_t               offered;
  logic signed [KEY_W-1:0] used_keys[$];

  // Shadow copy of the leaf contents
  logic signed [KEY_W-1:0] tbl_key [CAPACITY];
  logic [PAGE_W-1:0]       tbl_page[CAPACITY];
  logic [SLOT_W-1:0]       tbl_slot[CAPACITY];
  int unsigned             tbl_n = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_arm      = 1'b0;
  bit          hold_done     = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned err_cnt       = 0;
  int unsigned cyc_cnt       = 0;

  // ------------------------------------------------------------------
  // Table model
  // ------------------------------------------------------------------
  function automatic void push_resp(status_e s, int unsigned pos,
                                    logic signed [KEY_W-1:0] k,
                                    logic [PAGE_W-1:0] p,
                                    logic [SLOT_W-1:0] sl, logic last);
    leaf_resp_t r;
    r.status   = s;
    r.position = pos[IDX_W-1:0];
    r.key      = k;
    r.page     = p;
    r.slot     = sl;
    r.count    = tbl_n[CNT_W-1:0];
    r.last     = last;
    resp_q.push_back(r);
  endfunction

  function automatic void leaf_apply(leaf_req_t r);
    logic signed [KEY_W-1:0] mk[CAPACITY+1];
    logic [PAGE_W-1:0]       mp[CAPACITY+1];
    logic [SLOT_W-1:0]       ms[CAPACITY+1];
    int unsigned             at, j, total, keep;
    bit                      hit;
    // read ignores the key entirely
    if (r.cmd == CMD_READ) begin
      if (r.idx >= tbl_n)
        push_resp(STS_BAD_INDEX, r.idx, '0, '0, '0, 1'b1);
      else
        push_resp(STS_OK, r.idx, tbl_key[r.idx], tbl_page[r.idx],
                  tbl_slot[r.idx], 1'b1);
      return;
    end
    if (r.key == 0) begin
      push_resp(STS_ZERO_KEY, 0, '0, '0, '0, 1'b1);
      return;
    end
    // first slot holding a key not below the search key
    at = 0;
    while (at < tbl_n && tbl_key[at] < r.key) at++;
    hit = (at < tbl_n) && (tbl_key[at] == r.key);
    if (r.cmd == CMD_LOCATE) begin
      push_resp(hit ? STS_OK : STS_NOT_FOUND, at, '0, '0, '0, 1'b1);
      return;
    end
    if (hit) begin
      push_resp(STS_DUP, at, '0, '0, '0, 1'b1);
      return;
    end
    if (r.cmd == CMD_INSERT) begin
      if (tbl_n >= CAPACITY) begin
        push_resp(STS_FULL, 0, '0, '0, '0, 1'b1);
        return;
      end
      for (int unsigned i = tbl_n; i > at; i--) begin
        tbl_key[i]  = tbl_key[i-1];
        tbl_page[i] = tbl_page[i-1];
        tbl_slot[i] = tbl_slot[i-1];
      end
      tbl_key[at]  = r.key;
      tbl_page[at] = r.page;
      tbl_slot[at] = r.slot;
      tbl_n++;
      push_resp(STS_OK, at, '0, '0, '0, 1'b1);
      return;
    end
    // split: merge the new entry, keep the lower half, emit the rest
    j = 0;
    for (int unsigned i = 0; i < tbl_n; i++) begin
      if (i == at) begin
        mk[j] = r.key; mp[j] = r.page; ms[j] = r.slot; j++;
      end
      mk[j] = tbl_key[i]; mp[j] = tbl_page[i]; ms[j] = tbl_slot[i]; j++;
    end
    if (at >= tbl_n) begin
      mk[j] = r.key; mp[j] = r.page; ms[j] = r.slot; j++;
    end
    total = j;
    keep  = total / 2;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (i < keep) begin
        tbl_key[i] = mk[i]; tbl_page[i] = mp[i]; tbl_slot[i] = ms[i];
      end else begin
        tbl_key[i] = '0;
      end
    end
    tbl_n = keep;
    for (int unsigned i = keep; i < total; i++)
      push_resp(STS_OK, i - keep, mk[i], mp[i], ms[i], (i + 1 == total));
  endfunction

  // ------------------------------------------------------------------
  // Clock
  // ------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------
  // Request driver: predicts each accepted transaction, then offers more
  // ------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) leaf_apply(offered);
      if (!in_if.valid || in_if.ready) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = req_q.pop_front();
          in_if.valid       <= 1'b1;
          in_if.cmd         <= offered.cmd;
          in_if.key         <= offered.key;
          in_if.rid_page    <= offered.page;
          in_if.rid_slot    <= offered.slot;
          in_if.entry_index <= offered.idx;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Response ready: random idling plus one long hold-off when armed
  // ------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ------------------------------------------------------------------
  // Response monitor
  // ------------------------------------------------------------------
  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    leaf_resp_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (resp_q.size() == 0) begin
        $error("unexpected response: status %0d key %0d", out_if.status, out_if.out_key);
        err_cnt++;
      end else begin
        e = resp_q.pop_front();
        check_field("status",      e.status,   out_if.status);
        check_field("position",    e.position, out_if.position);
        check_field("out_key",     e.key,      out_if.out_key);
        check_field("out_page",    e.page,     out_if.out_page);
        check_field("out_slot",    e.slot,     out_if.out_slot);
        check_field("entry_count", e.count,    out_if.entry_count);
        check_field("last",        e.last,     out_if.last);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic logic [PAGE_W-1:0] rnd_page();
    return PAGE_W'($urandom());
  endfunction

  function automatic logic [SLOT_W-1:0] rnd_slot();
    return SLOT_W'($urandom());
  endfunction

  // mostly near the current fill level, sometimes anywhere in range
  function automatic logic [IDX_W-1:0] rnd_idx();
    if ($urandom_range(3) == 0) return IDX_W'($urandom_range(127));
    return IDX_W'($urandom_range(tbl_n + 2));
  endfunction

  function automatic logic signed [KEY_W-1:0] fresh_key();
    logic signed [KEY_W-1:0] k;
    do k = $urandom(); while (k == 0);
    return k;
  endfunction

  function automatic logic signed [KEY_W-1:0] used_key();
    if (used_keys.size() == 0) return fresh_key();
    return used_keys[$urandom_range(used_keys.size() - 1)];
  endfunction

  // blend of known keys, zero, extremes and fresh values
  function automatic logic signed [KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 30) return used_key();
    if (sel < 36) return '0;
    if (sel < 44) begin
      case ($urandom_range(3))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return 1;
        default: return -1;
      endcase
    end
    return fresh_key();
  endfunction

  function automatic void queue_req(cmd_e c, logic signed [KEY_W-1:0] k,
                                    logic [PAGE_W-1:0] p, logic [SLOT_W-1:0] s,
                                    logic [IDX_W-1:0] ix);
    leaf_req_t r;
    r.cmd  = c;
    r.key  = k;
    r.page = p;
    r.slot = s;
    r.idx  = ix;
    req_q.push_back(r);
    if ((c == CMD_INSERT || c == CMD_SPLIT) && k != 0) used_keys.push_back(k);
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_q.size() != 0 || in_if.valid || resp_q.size() != 0);
  endtask

  // One phase: optional fill to capacity with a full-table split, then mixed
  task automatic run_phase(int unsigned s_idle, int unsigned r_idle, bit fill,
                           int unsigned n_mixed, bit hold);
    logic signed [KEY_W-1:0] fill_keys[$];
    logic signed [KEY_W-1:0] k;
    int unsigned             need, sel;
    wait_drained();
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    hold_arm      = hold;
    if (fill) begin
      need = CAPACITY - tbl_n;
      while (need != 0) begin
        sel = $urandom_range(99);
        if (sel < 80 || fill_keys.size() == 0) begin
          k = fresh_key();
          fill_keys.push_back(k);
          queue_req(CMD_INSERT, k, rnd_page(), rnd_slot(), rnd_idx());
          need--;
        end else if (sel < 88) begin
          queue_req(CMD_LOCATE, pick_key(), rnd_page(), rnd_slot(), rnd_idx());
        end else if (sel < 95) begin
          queue_req(CMD_READ, $urandom(), rnd_page(), rnd_slot(), rnd_idx());
        end else begin
          // duplicate of a key placed in this fill
          k = fill_keys[$urandom_range(fill_keys.size() - 1)];
          queue_req(CMD_INSERT, k, rnd_page(), rnd_slot(), rnd_idx());
        end
      end
      repeat (2) queue_req(CMD_INSERT, fresh_key(), rnd_page(), rnd_slot(), rnd_idx());
      queue_req(CMD_SPLIT, fresh_key(), rnd_page(), rnd_slot(), rnd_idx());
    end
    repeat (n_mixed) begin
      sel = $urandom_range(99);
      if (sel < 35)
        queue_req(CMD_INSERT, pick_key(), rnd_page(), rnd_slot(), rnd_idx());
      else if (sel < 55)
        queue_req(CMD_LOCATE, pick_key(), rnd_page(), rnd_slot(), rnd_idx());
      else if (sel < 75)
        queue_req(CMD_READ, pick_key(), rnd_page(), rnd_slot(), rnd_idx());
      else
        queue_req(CMD_SPLIT, pick_key(), rnd_page(), rnd_slot(), rnd_idx());
    end
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.cmd          = CMD_INSERT;
    in_if.key          = '0;
    in_if.rid_page     = '0;
    in_if.rid_slot     = '0;
    in_if.entry_index  = '0;
    out_if.ready       = 1'b0;
    send_idle_pct      = 12;
    recv_idle_pct      = 76;
    for (int i = 0; i < CAPACITY; i++) begin
      tbl_key[i]  = '0;
      tbl_page[i] = '0;
      tbl_slot[i] = '0;
    end

    // empty table: miss, bad read, split of a lone entry
    queue_req(CMD_LOCATE, 7, rnd_page(), rnd_slot(), 0);
    queue_req(CMD_READ, 0, rnd_page(), rnd_slot(), 0);
    queue_req(CMD_SPLIT, 5, rnd_page(), rnd_slot(), 0);
    // zero key is rejected by every keyed command
    queue_req(CMD_INSERT, 0, rnd_page(), rnd_slot(), 0);
    queue_req(CMD_LOCATE, 0, rnd_page(), rnd_slot(), 0);
    queue_req(CMD_SPLIT, 0, rnd_page(), rnd_slot(), 0);
    // extremes of key and record id
    queue_req(CMD_INSERT, KEY_MAX, '1, '1, '1);
    queue_req(CMD_INSERT, KEY_MIN, '0, '0, '0);
    queue_req(CMD_INSERT, 1, rnd_page(), rnd_slot(), 0);
    queue_req(CMD_INSERT, -1, rnd_page(), rnd_slot(), 0);
    // duplicates
    queue_req(CMD_INSERT, KEY_MAX, rnd_page(), rnd_slot(), 0);
    queue_req(CMD_SPLIT, KEY_MIN, rnd_page(), rnd_slot(), 0);
    // locate hits and misses on both sides
    queue_req(CMD_LOCATE, 1, rnd_page(), rnd_slot(), 0);
    queue_req(CMD_LOCATE, 2, rnd_page(), rnd_slot(), 0);
    queue_req(CMD_LOCATE, KEY_MAX, rnd_page(), rnd_slot(), 0);
    queue_req(CMD_LOCATE, KEY_MIN, rnd_page(), rnd_slot(), 0);
    queue_req(CMD_LOCATE, -5, rnd_page(), rnd_slot(), 0);
    // reads in and out of range; key field is don't-care
    queue_req(CMD_READ, 0, rnd_page(), rnd_slot(), 0);
    queue_req(CMD_READ, fresh_key(), rnd_page(), rnd_slot(), 3);
    queue_req(CMD_READ, 0, rnd_page(), rnd_slot(), 4);
    queue_req(CMD_READ, KEY_MAX, rnd_page(), rnd_slot(), 127);
    // five entries, new key lands right at the split point
    queue_req(CMD_INSERT, 100, rnd_page(), rnd_slot(), 0);
    queue_req(CMD_SPLIT, 50, rnd_page(), rnd_slot(), 0);
    queue_req(CMD_READ, 0, rnd_page(), rnd_slot(), 2);
    queue_req(CMD_LOCATE, 100, rnd_page(), rnd_slot(), 0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_phase(12, 76, 1'b1, 12, 1'b0);
    run_phase(76, 12, 1'b1, 12, 1'b0);
    run_phase(0, 0, 1'b0, 60, 1'b1);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (resp_q.size() != 0) begin
      $error("%0d responses never arrived", resp_q.size());
      err_cnt++;
    end
    if (err_cnt == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
